>>> sv/blkb_pkg.sv
// ----------------------------------------------------------------------------
// blkb_pkg
// shared types, register map and helpers of the block-boundary blockiness unit
// ----------------------------------------------------------------------------
`default_nettype none

package blkb_pkg;

  // register map, index is paddr[3:2]
  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_COMPONENTS   = 2'd2;

  localparam int DIM_W  = 13;
  localparam int COMP_W = 3;
  localparam int SUM_W  = 33;
  localparam int ROW_W  = 12;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [COMP_W-1:0] RST_COMPONENTS   = 3'd3;

  // per-sample edge decisions, travel from the raster counters to the accumulator
  typedef struct packed {
    logic vert_edge;   // left neighbour lies across a vertical block edge
    logic horiz_edge;  // upper neighbour lies across a horizontal block edge
    logic line_wr;     // sample belongs to row 8n+7, keep it in the line buffer
    logic frame_end;   // last sample of the frame
  } edge_flags_t;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

>>> sv/block_boundary_blockiness_unit.sv
// ----------------------------------------------------------------------------
// block_boundary_blockiness_unit
// sum of absolute sample differences across 8x8 block edges of a raster frame
// ----------------------------------------------------------------------------
// a frame's sum passes the stage register, then the result register
// throughput: one sample beat per cycle unless a frame end meets a held result;
//   set by the single-pass datapath and a line buffer read plus write per cycle
// reset: counters, accumulator and handshakes cleared, registers return to
//   640 x 480 x 3; line buffer and previous-pixel store are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module block_boundary_blockiness_unit
  import blkb_pkg::*;
#(
  parameter int MAX_WIDTH      = 4096,
  parameter int MAX_COMPONENTS = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // sample stream
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         sample_i,
  // result stream
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [SUM_W-1:0]   blockiness_o,
  // apb configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int CNT_W      = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int LINE_DEPTH = MAX_WIDTH * MAX_COMPONENTS;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0]  image_width_q;
  logic [DIM_W-1:0]  image_height_q;
  logic [COMP_W-1:0] components_q;
  logic              cfg_wr;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  // write lands on the access phase
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= RST_IMAGE_WIDTH;
      image_height_q <= RST_IMAGE_HEIGHT;
      components_q   <= RST_COMPONENTS;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_IMAGE_WIDTH:  image_width_q  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height_q <= pwdata[DIM_W-1:0];
        REG_COMPONENTS:   components_q   <= pwdata[COMP_W-1:0];
        default: ;  // writes beyond the map are dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = {19'd0, image_width_q};
      REG_IMAGE_HEIGHT: prdata = {19'd0, image_height_q};
      REG_COMPONENTS:   prdata = {29'd0, components_q};
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // input side: raster position, previous-pixel store, line buffer
  // --------------------------------------------------------------------------
  logic               accept;
  logic [CNT_W-1:0]   comp;
  logic [LINE_AW-1:0] line_idx;
  edge_flags_t        flags;
  logic [7:0]         prev_q [MAX_COMPONENTS];
  logic [7:0]         line_rdata;

  assign accept = in_valid_i && in_ready_o;

  blkb_raster #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_raster (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (accept),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .components_i   (components_q),
    .comp_o         (comp),
    .line_idx_o     (line_idx),
    .flags_o        (flags)
  );

  // left neighbour per component, read before this beat overwrites it
  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_q[comp] <= sample_i;
    end
  end

  // row 8n+7 is written here and read back by row 8n+8, a full row later;
  // the read that shares a cycle with a write of the same entry is never used
  blkb_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (accept && flags.line_wr),
    .waddr_i (line_idx),
    .wdata_i (sample_i),
    .re_i    (accept),
    .raddr_i (line_idx),
    .rdata_o (line_rdata)
  );

  // --------------------------------------------------------------------------
  // difference stage, accumulator and result register
  // --------------------------------------------------------------------------
  blkb_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .ready_o      (in_ready_o),
    .sample_i     (sample_i),
    .prev_i       (prev_q[comp]),
    .flags_i      (flags),
    .line_i       (line_rdata),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .blockiness_o (blockiness_o)
  );

endmodule

`default_nettype wire

>>> sv/blkb_ram.sv
// ----------------------------------------------------------------------------
// blkb_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module blkb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/blkb_raster.sv
// ----------------------------------------------------------------------------
// blkb_raster
// raster position counters with clamped frame geometry and edge decisions
// ----------------------------------------------------------------------------
`default_nettype none

module blkb_raster
  import blkb_pkg::*;
#(
  parameter int MAX_WIDTH      = 4096,
  parameter int MAX_COMPONENTS = 4,
  parameter int COL_W   = $clog2(MAX_WIDTH),
  parameter int CNT_W   = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1,
  parameter int LINE_AW = $clog2(MAX_WIDTH * MAX_COMPONENTS)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               advance_i,
  input  wire logic [DIM_W-1:0]   image_width_i,
  input  wire logic [DIM_W-1:0]   image_height_i,
  input  wire logic [COMP_W-1:0]  components_i,
  output logic      [CNT_W-1:0]   comp_o,
  output logic      [LINE_AW-1:0] line_idx_o,
  output edge_flags_t             flags_o
);

  localparam logic [14:0]       MaxWidthW  = 15'(MAX_WIDTH);
  localparam logic [14:0]       MaxColLast = 15'(MAX_WIDTH - 1);
  localparam logic [COMP_W-1:0] MaxCompW   = COMP_W'(MAX_COMPONENTS);
  localparam logic [COMP_W-1:0] MaxCompLast = COMP_W'(MAX_COMPONENTS - 1);
  localparam logic [DIM_W-1:0]  MaxHeightW = DIM_W'(MAX_HEIGHT);

  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [CNT_W-1:0]  comp_q, comp_d;
  logic [14:0]       col_last;
  logic [ROW_W-1:0]  row_last;
  logic [COMP_W-1:0] comp_last;
  logic              comp_wrap, col_wrap, row_wrap;

  // last index of each counter, out-of-range settings clamped
  always_comb begin
    if (image_width_i == '0) begin
      col_last = '0;
    end else if ({2'b00, image_width_i} > MaxWidthW) begin
      col_last = MaxColLast;
    end else begin
      col_last = {2'b00, image_width_i} - 15'd1;
    end

    if (image_height_i == '0) begin
      row_last = '0;
    end else if (image_height_i > MaxHeightW) begin
      row_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      row_last = ROW_W'(image_height_i - 13'd1);
    end

    if (components_i == '0) begin
      comp_last = '0;
    end else if (components_i > MaxCompW) begin
      comp_last = MaxCompLast;
    end else begin
      comp_last = components_i - 3'd1;
    end
  end

  assign comp_wrap = (COMP_W'(comp_q) >= comp_last);
  assign col_wrap  = (15'(col_q) >= col_last);
  assign row_wrap  = (row_q >= row_last);

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    comp_d = comp_q;
    if (comp_wrap) begin
      comp_d = '0;
      if (col_wrap) begin
        col_d = '0;
        if (row_wrap) begin
          row_d = '0;
        end else begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end else begin
      comp_d = comp_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      comp_q <= '0;
    end else if (advance_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      comp_q <= comp_d;
    end
  end

  assign comp_o     = comp_q;
  assign line_idx_o = LINE_AW'(32'(col_q) * 32'(MAX_COMPONENTS) + 32'(comp_q));

  assign flags_o.vert_edge  = (col_q != '0) && (col_q[2:0] == 3'd0);
  assign flags_o.horiz_edge = (row_q != '0) && (row_q[2:0] == 3'd0);
  assign flags_o.line_wr    = (row_q[2:0] == 3'd7);
  assign flags_o.frame_end  = comp_wrap && col_wrap && row_wrap;

endmodule

`default_nettype wire

>>> sv/blkb_accum.sv
// ----------------------------------------------------------------------------
// blkb_accum
// difference stage, frame accumulator and result register
// ----------------------------------------------------------------------------
`default_nettype none

module blkb_accum
  import blkb_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  output logic                  ready_o,
  input  wire logic [7:0]       sample_i,
  input  wire logic [7:0]       prev_i,
  input  wire edge_flags_t      flags_i,
  input  wire logic [7:0]       line_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [SUM_W-1:0] blockiness_o
);

  logic              s1_valid_q, s1_valid_d;
  logic [7:0]        s1_sample_q, s1_prev_q;
  edge_flags_t       s1_flags_q;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              out_valid_q, out_valid_d;
  logic [SUM_W-1:0]  out_data_q;
  logic [7:0]        vert_diff, horiz_diff;
  logic [SUM_W-1:0]  total;
  logic              s1_adv;

  // line_i is the registered ram output, aligned with the stage registers
  assign vert_diff  = s1_flags_q.vert_edge  ? abs_diff(s1_prev_q, s1_sample_q) : 8'd0;
  assign horiz_diff = s1_flags_q.horiz_edge ? abs_diff(line_i, s1_sample_q)    : 8'd0;
  assign total = sum_q + SUM_W'(vert_diff) + SUM_W'(horiz_diff);

  // only a frame-end beat needs the result register free
  assign s1_adv  = s1_valid_q && (!s1_flags_q.frame_end || !out_valid_q || out_ready_i);
  assign ready_o = !s1_valid_q || s1_adv;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_adv) begin
      s1_valid_d = 1'b0;
      if (s1_flags_q.frame_end) begin
        sum_d       = '0;
        out_valid_d = 1'b1;
      end else begin
        sum_d = total;
      end
    end
    if (load_i) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_sample_q <= sample_i;
      s1_prev_q   <= prev_i;
      s1_flags_q  <= flags_i;
    end
    if (s1_adv && s1_flags_q.frame_end) begin
      out_data_q <= total;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign blockiness_o = out_data_q;

endmodule

`default_nettype wire
